>>> rtl/core/arpf_pkg.sv
// Package for the audio RTP payload framer.
// Holds the codec codes, header constants, queue sizing and the command type
// passed between the front, queue and back modules. No dependencies.
package arpf_pkg;

   // Default width of the unit length field.
   localparam int LENGTH_BITS_DEFAULT = 14;

   // Codec kinds on the mode field.
   localparam logic [1:0] MODE_AAC   = 2'd0;
   localparam logic [1:0] MODE_ALAW  = 2'd1;
   localparam logic [1:0] MODE_MULAW = 2'd2;
   localparam logic [1:0] MODE_OTHER = 2'd3;

   // ADTS detection constants.
   localparam logic [7:0] ADTS_SYNC_HI   = 8'hFF;
   localparam logic [3:0] ADTS_SYNC_LO   = 4'hF;
   localparam logic [3:0] ADTS_HDR_SHORT = 4'd7;
   localparam logic [3:0] ADTS_HDR_LONG  = 4'd9;

   // Fixed leading bytes of the AU header section (16 bits of header length).
   localparam logic [7:0] AUH_BYTE0 = 8'h00;
   localparam logic [7:0] AUH_BYTE1 = 8'h10;

   // Width of the AU size field carried in the header.
   localparam int AU_SIZE_BITS = 13;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // One classified item: which result bytes the back end has to produce.
   typedef struct packed {
      logic                    has_hdr;
      logic [AU_SIZE_BITS-1:0] au_size;
      logic                    has_held;
      logic [7:0]              held_byte;
      logic                    has_byte;
      logic [7:0]              data_byte;
      logic                    last;
      logic [31:0]             timestamp;
   } cmd_type;

   // Back end sequencer position within one command.
   typedef enum logic [2:0] {
      SEQ_START,
      SEQ_HDR1,
      SEQ_HDR2,
      SEQ_HDR3,
      SEQ_HELD,
      SEQ_BYTE
   } seq_state_type;

   // Result byte currently being produced.
   typedef enum logic [2:0] {
      ELEM_HDR0,
      ELEM_HDR1,
      ELEM_HDR2,
      ELEM_HDR3,
      ELEM_HELD,
      ELEM_BYTE
   } elem_type;

endpackage

>>> rtl/core/arpf_front.sv
// Front end of the audio RTP payload framer: accepts input transfers, tracks
// the position within the access unit, detects ADTS headers and issues commands.
// Depends on arpf_pkg.
module arpf_front #(
   parameter int LENGTH_BITS = arpf_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_mode,
   input  logic [7:0]             req_in_byte,
   input  logic [LENGTH_BITS-1:0] req_unit_length,
   input  logic [31:0]            req_in_timestamp,
   input  logic                   queue_full,
   output logic                   cmd_push,
   output arpf_pkg::cmd_type      cmd_out
);
   import arpf_pkg::*;

   localparam int LB = LENGTH_BITS;

   logic [LB-1:0] pos_ff, pos_in;
   logic [7:0]    held_ff, held_in;
   logic [3:0]    strip_ff, strip_in;
   logic          adts_ff, adts_in;

   logic [LB-1:0] len_eff;
   logic          last;
   logic          pos_first;
   logic          pos_second;
   logic          accept;
   logic [LB-1:0] hdr_len;
   logic          detect;
   logic [LB-1:0] len_less_hdr;
   logic          past_strip;
   logic          emit;

   // A zero length counts as a one-byte unit.
   assign len_eff    = (req_unit_length == '0) ? LB'(1) : req_unit_length;
   assign last       = ({1'b0, pos_ff} + (LB+1)'(1)) >= {1'b0, len_eff};
   assign pos_first  = (pos_ff == '0);
   assign pos_second = (pos_ff == LB'(1));
   assign accept     = req_valid && req_ready;
   assign req_ready  = !queue_full;

   // ADTS header detection on the second byte of an AAC unit.
   assign hdr_len = req_in_byte[0] ? {{(LB-4){1'b0}}, ADTS_HDR_SHORT}
                                   : {{(LB-4){1'b0}}, ADTS_HDR_LONG};
   assign detect  = (len_eff >= {{(LB-4){1'b0}}, ADTS_HDR_SHORT})
                    && (held_ff == ADTS_SYNC_HI)
                    && (req_in_byte[7:4] == ADTS_SYNC_LO)
                    && (len_eff >= hdr_len);
   assign len_less_hdr = len_eff - hdr_len;
   assign past_strip   = pos_ff >= {{(LB-4){1'b0}}, strip_ff};

   // Classify the transfer into a command for the back end.
   always_comb begin
      logic [16:0] len_ext;
      logic [16:0] rem_ext;
      len_ext = {{(17-LB){1'b0}}, len_eff};
      rem_ext = {{(17-LB){1'b0}}, len_less_hdr};
      emit                = 1'b0;
      cmd_out.has_hdr     = 1'b0;
      cmd_out.au_size     = len_ext[AU_SIZE_BITS-1:0];
      cmd_out.has_held    = 1'b0;
      cmd_out.held_byte   = held_ff;
      cmd_out.has_byte    = 1'b0;
      cmd_out.data_byte   = req_in_byte;
      cmd_out.last        = last;
      cmd_out.timestamp   = req_in_timestamp;
      unique case (req_mode)
         MODE_AAC: begin
            if (pos_first) begin
               emit             = last;
               cmd_out.has_hdr  = 1'b1;
               cmd_out.has_byte = 1'b1;
            end else if (pos_second) begin
               if (detect) begin
                  emit            = (len_eff > hdr_len);
                  cmd_out.has_hdr = 1'b1;
                  cmd_out.au_size = rem_ext[AU_SIZE_BITS-1:0];
               end else begin
                  emit             = 1'b1;
                  cmd_out.has_hdr  = 1'b1;
                  cmd_out.has_held = 1'b1;
                  cmd_out.has_byte = 1'b1;
               end
            end else begin
               emit             = !adts_ff || past_strip;
               cmd_out.has_byte = 1'b1;
            end
         end
         MODE_ALAW, MODE_MULAW: begin
            emit             = 1'b1;
            cmd_out.has_byte = 1'b1;
         end
         MODE_OTHER: begin
            emit = 1'b0;
         end
      endcase
   end

   assign cmd_push = accept && emit;

   // Unit tracking state updates on each accepted transfer.
   always_comb begin
      pos_in   = pos_ff;
      held_in  = held_ff;
      strip_in = strip_ff;
      adts_in  = adts_ff;
      if (accept) begin
         pos_in = last ? '0 : (pos_ff + LB'(1));
         if (pos_first) begin
            held_in  = req_in_byte;
            strip_in = '0;
            adts_in  = 1'b0;
         end else if (pos_second && (req_mode == MODE_AAC) && detect) begin
            strip_in = hdr_len[3:0];
            adts_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         strip_ff <= '0;
         adts_ff  <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         strip_ff <= strip_in;
         adts_ff  <= adts_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

>>> rtl/core/arpf_queue.sv
// Short command queue between the framer's front and back ends.
// Register based, one push (while not full) and one pop per cycle. Depends on arpf_pkg.
module arpf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  arpf_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output arpf_pkg::cmd_type head_data
);
   import arpf_pkg::*;

   cmd_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full       = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? (wr_ptr_ff + QUEUE_PTR_BITS'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? (rd_ptr_ff + QUEUE_PTR_BITS'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/arpf_back.sv
// Back end of the audio RTP payload framer: expands each command into its AU
// header and payload bytes, one per cycle unless stalled. Depends on arpf_pkg.
module arpf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  arpf_pkg::cmd_type head_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic [31:0]       rsp_out_timestamp,
   output logic              rsp_end_of_packet
);
   import arpf_pkg::*;

   seq_state_type state_ff, state_in;
   elem_type      elem;
   logic          fire;
   logic          valid_ff, valid_in;
   logic [7:0]    byte_ff, byte_in;
   logic [31:0]   ts_ff;
   logic          eop_ff, eop_in;
   logic [15:0]   size_field;

   // The output register can load when empty or when its transfer completes.
   assign fire       = head_valid && (!valid_ff || rsp_ready);
   assign size_field = {head_data.au_size, 3'b000};

   // Resolve which byte of the command is due now.
   always_comb begin
      unique case (state_ff)
         SEQ_START: begin
            if (head_data.has_hdr) begin
               elem = ELEM_HDR0;
            end else if (head_data.has_held) begin
               elem = ELEM_HELD;
            end else begin
               elem = ELEM_BYTE;
            end
         end
         SEQ_HDR1: elem = ELEM_HDR1;
         SEQ_HDR2: elem = ELEM_HDR2;
         SEQ_HDR3: elem = ELEM_HDR3;
         SEQ_HELD: elem = ELEM_HELD;
         SEQ_BYTE: elem = ELEM_BYTE;
         default:  elem = ELEM_BYTE;
      endcase
   end

   // Next sequencer state.
   always_comb begin
      state_in = state_ff;
      if (fire) begin
         unique case (elem)
            ELEM_HDR0: state_in = SEQ_HDR1;
            ELEM_HDR1: state_in = SEQ_HDR2;
            ELEM_HDR2: state_in = SEQ_HDR3;
            ELEM_HDR3: begin
               if (head_data.has_held) begin
                  state_in = SEQ_HELD;
               end else if (head_data.has_byte) begin
                  state_in = SEQ_BYTE;
               end else begin
                  state_in = SEQ_START;
               end
            end
            ELEM_HELD: state_in = head_data.has_byte ? SEQ_BYTE : SEQ_START;
            ELEM_BYTE: state_in = SEQ_START;
            default:   state_in = SEQ_START;
         endcase
      end
   end

   // Sequencer outputs: result byte, marker and queue pop.
   always_comb begin
      byte_in = byte_ff;
      eop_in  = eop_ff;
      pop     = 1'b0;
      if (fire) begin
         eop_in = 1'b0;
         unique case (elem)
            ELEM_HDR0: byte_in = AUH_BYTE0;
            ELEM_HDR1: byte_in = AUH_BYTE1;
            ELEM_HDR2: byte_in = size_field[15:8];
            ELEM_HDR3: begin
               byte_in = size_field[7:0];
               pop     = !head_data.has_held && !head_data.has_byte;
            end
            ELEM_HELD: begin
               byte_in = head_data.held_byte;
               pop     = !head_data.has_byte;
            end
            ELEM_BYTE: begin
               byte_in = head_data.data_byte;
               eop_in  = head_data.last;
               pop     = 1'b1;
            end
            default: byte_in = head_data.data_byte;
         endcase
      end
   end

   assign valid_in = fire || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_START;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      eop_ff  <= eop_in;
      if (fire) begin
         ts_ff <= head_data.timestamp;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_out_timestamp = ts_ff;
   assign rsp_end_of_packet = eop_ff;

endmodule

>>> rtl/core/audio_rtp_payload_framer_core.sv
// Audio RTP payload framer, top level: front end, command queue and back end.
// A result byte goes through a queue entry and the output register after its input.
// Throughput: one input transfer per cycle while the queue is not full and one
// result transfer per cycle while rsp_ready is high; an AAC unit adds four AU header
// bytes, which the 4-entry queue absorbs, so steady input stalls while they drain.
// Reset: synchronous, active high; clears unit position, ADTS state, queue and back end.
// Depends on arpf_pkg, arpf_front, arpf_queue and arpf_back.
module audio_rtp_payload_framer_core #(
   parameter int LENGTH_BITS = arpf_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_mode,
   input  logic [7:0]             req_in_byte,
   input  logic [LENGTH_BITS-1:0] req_unit_length,
   input  logic [31:0]            req_in_timestamp,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic [31:0]            rsp_out_timestamp,
   output logic                   rsp_end_of_packet
);
   import arpf_pkg::*;

   cmd_type push_data;
   cmd_type head_data;
   logic    push;
   logic    full;
   logic    pop;
   logic    head_valid;

   // Classification of incoming transfers.
   arpf_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_in_byte      (req_in_byte),
      .req_unit_length  (req_unit_length),
      .req_in_timestamp (req_in_timestamp),
      .queue_full       (full),
      .cmd_push         (push),
      .cmd_out          (push_data)
   );

   // Decoupling queue.
   arpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Result byte generation.
   arpf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_data         (head_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_timestamp (rsp_out_timestamp),
      .rsp_end_of_packet (rsp_end_of_packet)
   );

endmodule
